// ===== hdl/flood_duplicate_filter_core_defines.svh =====
// Assertion helpers shared by the RTL of the flood duplicate filter.
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the scope where it is used.
`ifndef FLOOD_DUPLICATE_FILTER_CORE_DEFINES_SVH
`define FLOOD_DUPLICATE_FILTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flood filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flood filter assertion failed");

`endif

// ===== hdl/fdf_pkg.sv =====
`timescale 1ns / 1ps

package fdf_pkg;

    // Field widths of the packet header.
    localparam int ADDR_W = 16;
    localparam int SEQ_W  = 8;
    localparam int HOP_W  = 8;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SEQ_W-1:0]  seq_t;
    typedef logic [HOP_W-1:0]  hop_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    // Operation codes carried by an input item.
    localparam logic OPCODE_RECV = 1'b0;
    localparam logic OPCODE_SEND = 1'b1;

    // Configuration register indexes.
    localparam cfg_index_t REG_HOP_LIMIT    = 1'b0;
    localparam cfg_index_t REG_NODE_ADDRESS = 1'b1;

    // Reset values of the configuration registers.
    localparam hop_t  HOP_LIMIT_RESET    = 8'd16;
    localparam addr_t NODE_ADDRESS_RESET = 16'd0;

endpackage

// ===== hdl/fdf_if.sv =====
`timescale 1ns / 1ps

// Input channel: one packet event per transfer.
interface fdf_in_if;
    import fdf_pkg::*;

    logic  valid;
    logic  ready;
    logic  opcode;
    addr_t originator_addr;
    seq_t  rx_seqno;
    hop_t  hop_count;
    logic  app_accepts;
    logic  buffer_available;
    logic  send_ok;

    modport source (
        output valid, opcode, originator_addr, rx_seqno, hop_count,
               app_accepts, buffer_available, send_ok,
        input  ready
    );

    modport sink (
        input  valid, opcode, originator_addr, rx_seqno, hop_count,
               app_accepts, buffer_available, send_ok,
        output ready
    );
endinterface

// Output channel: one verdict per transfer.
interface fdf_out_if;
    import fdf_pkg::*;

    logic valid;
    logic ready;
    logic deliver;
    logic forward;
    hop_t forward_hops;
    seq_t tx_seqno;
    logic send_done;

    modport source (
        output valid, deliver, forward, forward_hops, tx_seqno, send_done,
        input  ready
    );

    modport sink (
        input  valid, deliver, forward, forward_hops, tx_seqno, send_done,
        output ready
    );
endinterface

// ===== hdl/fdf_hist_ram.sv =====
`timescale 1ns / 1ps

// Single-port-write, single-port-read history memory with registered read data.
module fdf_hist_ram #(
    parameter int DEPTH    = 16,
    parameter int IDX_BITS = 4,
    parameter int WIDTH    = 24
) (
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]    wdata,
    input  logic [IDX_BITS-1:0] raddr,
    output logic [WIDTH-1:0]    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/flood_duplicate_filter_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Payload
// ---------+-----------+-----------------------------------------------------
// in_ch    | sink      | opcode, originator_addr, rx_seqno, hop_count,
//          |           | app_accepts, buffer_available, send_ok
// out_ch   | source    | deliver, forward, forward_hops, tx_seqno, send_done
// cfg_*    | write     | cfg_index selects hop_limit or node_address
//
// A miss scans every history entry before the result register is loaded:
// the history memory is scanned one entry per cycle through its single read
// port, each entry is compared in the cycle after its read, then the decide
// step decides and writes back. A hit at entry i ends the scan early. The next
// item can be taken once the decide step is done, even if the previous result
// has not been transferred yet. Reset clears the valid bits, the ring pointer
// and the local counter at once; there is no clearing pass. A stalled output
// holds the block in its decide step until the pending result is transferred.
module flood_duplicate_filter_core #(
    parameter int HISTORY_DEPTH = 16,
    parameter int ADDR_BITS     = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  fdf_pkg::cfg_index_t    cfg_index,
    input  fdf_pkg::cfg_data_t     cfg_data,
    fdf_in_if.sink                 in_ch,
    fdf_out_if.source              out_ch
);
    import fdf_pkg::*;

    `include "flood_duplicate_filter_core_defines.svh"

    localparam int IDX_BITS   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int KEY_BITS   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int ENTRY_BITS = KEY_BITS + SEQ_W;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(HISTORY_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    hop_t                hop_limit_reg;
    logic [KEY_BITS-1:0] node_addr_reg;

    // Captured item.
    logic                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    seq_t                seq_in_reg;
    hop_t                hops_reg;
    logic                app_reg;
    logic                buf_reg;
    logic                send_ok_reg;

    // History bookkeeping.
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [IDX_BITS-1:0]      rp_reg;
    seq_t                     local_seq_reg;

    // Scan pipeline.
    logic [IDX_BITS-1:0] rd_idx_reg;
    logic                cmp_vld_reg;
    logic [IDX_BITS-1:0] cmp_idx_reg;
    logic                hit_reg;
    logic [IDX_BITS-1:0] hit_idx_reg;
    seq_t                last_seq_reg;

    // Result register.
    logic out_valid_reg;
    logic deliver_reg;
    logic forward_reg;
    hop_t forward_hops_reg;
    seq_t tx_seqno_reg;
    logic send_done_reg;

    // Memory ports.
    logic                  ram_we;
    logic [IDX_BITS-1:0]   wr_slot;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    seq_t                  rd_seq;

    logic                  in_fire;
    logic                  entry_match;
    logic                  scan_end;
    seq_t                  rot_seq;
    logic [SEQ_W-2:0]      rx_count;
    logic [SEQ_W-2:0]      last_count;
    logic                  fresh;
    logic                  fwd_ok;
    logic                  send_rec;
    logic                  out_free;
    logic                  finish;
    seq_t                  wr_seq;
    logic [IDX_BITS-1:0]   rp_next;

    fdf_hist_ram #(
        .DEPTH    (HISTORY_DEPTH),
        .IDX_BITS (IDX_BITS),
        .WIDTH    (ENTRY_BITS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_slot),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Handshakes.
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign finish       = (state_reg == S_DECIDE) && out_free;

    // Compare the entry read in the previous cycle against the search key.
    assign rd_key      = ram_rdata[ENTRY_BITS-1:SEQ_W];
    assign rd_seq      = ram_rdata[SEQ_W-1:0];
    assign entry_match = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_key == key_reg);
    assign scan_end    = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);

    // The local counter rotated left by one: the top bit becomes the wrap marker.
    assign rot_seq = {local_seq_reg[SEQ_W-2:0], local_seq_reg[SEQ_W-1]};

    // Freshness: a missing entry, a larger count, or a smaller count with
    // the wrap marker flipped.
    assign rx_count   = seq_in_reg[SEQ_W-1:1];
    assign last_count = last_seq_reg[SEQ_W-1:1];
    assign fresh      = !hit_reg || (rx_count > last_count) ||
                        ((seq_in_reg[0] != last_seq_reg[0]) && (rx_count < last_count));

    assign fwd_ok   = (op_reg == OPCODE_RECV) && fresh && app_reg && buf_reg &&
                      (hops_reg < hop_limit_reg);
    assign send_rec = (op_reg == OPCODE_SEND) && send_ok_reg;

    // Write back into the hit entry, or into the ring slot on a miss.
    assign ram_we    = finish && (fwd_ok || send_rec);
    assign wr_slot   = hit_reg ? hit_idx_reg : rp_reg;
    assign wr_seq    = (op_reg == OPCODE_SEND) ? rot_seq : seq_in_reg;
    assign ram_wdata = {key_reg, wr_seq};
    assign rp_next   = (rp_reg == LAST_IDX) ? '0 : rp_reg + IDX_BITS'(1);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_limit_reg <= HOP_LIMIT_RESET;
            node_addr_reg <= NODE_ADDRESS_RESET[KEY_BITS-1:0];
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_HOP_LIMIT:    hop_limit_reg <= cfg_data[HOP_W-1:0];
                REG_NODE_ADDRESS: node_addr_reg <= cfg_data[KEY_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer: capture, scan, decide and write back, present the result.
    // Write-back finishes before the next item is taken, so a scan never
    // overlaps a write to the same entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            rp_reg           <= '0;
            local_seq_reg    <= '0;
            rd_idx_reg       <= '0;
            cmp_vld_reg      <= 1'b0;
            cmp_idx_reg      <= '0;
            hit_reg          <= 1'b0;
            hit_idx_reg      <= '0;
            last_seq_reg     <= '0;
            op_reg           <= OPCODE_RECV;
            key_reg          <= '0;
            seq_in_reg       <= '0;
            hops_reg         <= '0;
            app_reg          <= 1'b0;
            buf_reg          <= 1'b0;
            send_ok_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            deliver_reg      <= 1'b0;
            forward_reg      <= 1'b0;
            forward_hops_reg <= '0;
            tx_seqno_reg     <= '0;
            send_done_reg    <= 1'b0;
        end
        else
        begin
            // A transfer on the output frees the result register unless a
            // new result is loaded in the same cycle.
            if (out_valid_reg && out_ch.ready && !finish)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg      <= in_ch.opcode;
                        key_reg     <= (in_ch.opcode == OPCODE_SEND) ? node_addr_reg :
                                       in_ch.originator_addr[KEY_BITS-1:0];
                        seq_in_reg  <= in_ch.rx_seqno;
                        hops_reg    <= in_ch.hop_count;
                        app_reg     <= in_ch.app_accepts;
                        buf_reg     <= in_ch.buffer_available;
                        send_ok_reg <= in_ch.send_ok;
                        rd_idx_reg  <= '0;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    // Issue one read a cycle, compare each entry in the cycle after its read.
                    cmp_vld_reg <= 1'b1;
                    cmp_idx_reg <= rd_idx_reg;
                    if (rd_idx_reg != LAST_IDX)
                    begin
                        rd_idx_reg <= rd_idx_reg + IDX_BITS'(1);
                    end
                    if (entry_match)
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= cmp_idx_reg;
                        last_seq_reg <= rd_seq;
                        state_reg    <= S_DECIDE;
                    end
                    else if (scan_end)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        deliver_reg      <= (op_reg == OPCODE_RECV) && fresh;
                        forward_reg      <= fwd_ok;
                        forward_hops_reg <= fwd_ok ? hops_reg + HOP_W'(1) : '0;
                        tx_seqno_reg     <= (op_reg == OPCODE_SEND) ? rot_seq : '0;
                        send_done_reg    <= send_rec;
                        if (ram_we)
                        begin
                            valid_reg[wr_slot] <= 1'b1;
                            if (!hit_reg)
                            begin
                                rp_reg <= rp_next;
                            end
                        end
                        if (send_rec)
                        begin
                            local_seq_reg <= local_seq_reg + SEQ_W'(1);
                        end
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output channel.
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.deliver      = deliver_reg;
    assign out_ch.forward      = forward_reg;
    assign out_ch.forward_hops = forward_hops_reg;
    assign out_ch.tx_seqno     = tx_seqno_reg;
    assign out_ch.send_done    = send_done_reg;

    // An accepted item always starts a history scan.
    `FDF_ASSERT_NEXT(a_accept_starts_scan, in_fire, state_reg == S_SCAN)
    // A rebroadcast packet is always delivered as well.
    `FDF_ASSERT_SAME(a_forward_delivers, out_ch.valid && out_ch.forward, out_ch.deliver)
    // A write-back leaves its entry marked valid.
    `FDF_ASSERT_NEXT(a_write_sets_valid, ram_we, valid_reg[$past(wr_slot)])
    // The ring pointer stays inside the history.
    `FDF_ASSERT_SAME(a_rp_in_range, 1'b1, rp_reg <= LAST_IDX)

endmodule

// ===== tb/sv/flood_duplicate_filter_core_tb.sv =====
`timescale 1ns / 1ps

module flood_duplicate_filter_core_tb;
    import fdf_pkg::*;

    localparam int HIST_DEPTH = 16;
    localparam int ADDR_BITS = 16;
    // Scan of every history entry, then decide and write back.
    localparam int VERDICT_LATENCY = HIST_DEPTH + 3;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_POOL = 24;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

    typedef struct packed {
        logic  opcode;
        addr_t originator_addr;
        seq_t  rx_seqno;
        hop_t  hop_count;
        logic  app_accepts;
        logic  buffer_available;
        logic  send_ok;
    } packet_t;

    typedef struct packed {
        logic deliver;
        logic forward;
        hop_t forward_hops;
        seq_t tx_seqno;
        logic send_done;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    cfg_index_t cfg_index;
    cfg_data_t cfg_data;

    fdf_in_if in_ch ();
    fdf_out_if out_ch ();

    flood_duplicate_filter_core #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .ADDR_BITS    (ADDR_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // Mirror of the originator history and the local counter.
    addr_t origin_addr_tbl [HIST_DEPTH];
    seq_t origin_seq_tbl [HIST_DEPTH];
    logic origin_valid_tbl [HIST_DEPTH];
    int ring_slot;
    seq_t own_counter;
    hop_t cfg_hop_limit;
    addr_t cfg_node_address;

    packet_t packet_backlog[$];
    verdict_t pending_verdicts[$];
    int error_count;

    idle_mode_t sender_mode;
    idle_mode_t receiver_mode;
    int hold_requests;

    // Clock generation.
    always
    begin
        #5 clk = ~clk;
    end

    function automatic int draw_wait(idle_mode_t mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            default:    return $urandom_range(0, 18);
        endcase
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Lowest valid entry holding the address, or HIST_DEPTH on a miss.
    function automatic int find_origin(addr_t addr);
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            if (origin_valid_tbl[i] && origin_addr_tbl[i] == addr)
            begin
                return i;
            end
        end
        return HIST_DEPTH;
    endfunction

    // Overwrite the hit entry, or fill the ring slot and advance it.
    function automatic void store_origin(int hit, addr_t addr, seq_t seqno);
        int slot;
        slot = hit;
        if (hit >= HIST_DEPTH)
        begin
            slot = ring_slot;
            ring_slot = (ring_slot + 1) % HIST_DEPTH;
        end
        origin_addr_tbl[slot] = addr;
        origin_seq_tbl[slot] = seqno;
        origin_valid_tbl[slot] = 1'b1;
    endfunction

    function automatic verdict_t predict_verdict(packet_t pkt);
        verdict_t v;
        int hit;
        logic fresh;
        seq_t last;
        seq_t rotated;
        v = '0;
        if (pkt.opcode == OPCODE_RECV)
        begin
            hit = find_origin(pkt.originator_addr);
            if (hit >= HIST_DEPTH)
            begin
                fresh = 1'b1;
            end
            else
            begin
                last = origin_seq_tbl[hit];
                // Newer count, or a smaller count after the wrap marker flipped.
                fresh = (pkt.rx_seqno[7:1] > last[7:1])
                    || ((pkt.rx_seqno[0] != last[0]) && (pkt.rx_seqno[7:1] < last[7:1]));
            end
            if (fresh)
            begin
                v.deliver = 1'b1;
                if (pkt.app_accepts && pkt.buffer_available && pkt.hop_count < cfg_hop_limit)
                begin
                    v.forward = 1'b1;
                    v.forward_hops = pkt.hop_count + 8'd1;
                    store_origin(hit, pkt.originator_addr, pkt.rx_seqno);
                end
            end
        end
        else
        begin
            rotated = {own_counter[6:0], own_counter[7]};
            v.tx_seqno = rotated;
            if (pkt.send_ok)
            begin
                store_origin(find_origin(cfg_node_address), cfg_node_address, rotated);
                own_counter = own_counter + 8'd1;
                v.send_done = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic packet_t recv_pkt(addr_t addr, seq_t seqno, hop_t hops,
                                         logic app_ok, logic buf_ok);
        packet_t p;
        p.opcode = OPCODE_RECV;
        p.originator_addr = addr;
        p.rx_seqno = seqno;
        p.hop_count = hops;
        p.app_accepts = app_ok;
        p.buffer_available = buf_ok;
        p.send_ok = 1'($urandom);
        return p;
    endfunction

    // Unused receive fields carry random noise.
    function automatic packet_t send_pkt(logic ok);
        packet_t p;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        p = noise[$bits(packet_t)-1:0];
        p.opcode = OPCODE_SEND;
        p.send_ok = ok;
        return p;
    endfunction

    // Input driver: one transfer per packet from the backlog.
    packet_t cur_pkt;
    int gap_left;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                pending_verdicts.push_back(predict_verdict(cur_pkt));
                gap_left = draw_wait(sender_mode);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left == 0 && packet_backlog.size() > 0)
                begin
                    cur_pkt = packet_backlog.pop_front();
                    in_ch.opcode <= cur_pkt.opcode;
                    in_ch.originator_addr <= cur_pkt.originator_addr;
                    in_ch.rx_seqno <= cur_pkt.rx_seqno;
                    in_ch.hop_count <= cur_pkt.hop_count;
                    in_ch.app_accepts <= cur_pkt.app_accepts;
                    in_ch.buffer_available <= cur_pkt.buffer_available;
                    in_ch.send_ok <= cur_pkt.send_ok;
                    in_ch.valid <= 1'b1;
                end
                else
                begin
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output receiver: random stalls per verdict, plus the long hold-off on request.
    int stall_left;
    int hold_left;
    int hold_seen;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                stall_left = draw_wait(receiver_mode);
            end
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_ch.ready <= (hold_left == 0 && stall_left == 0);
        end
    end

    // Verdict monitor: compare every transfer with the oldest prediction.
    verdict_t got_verdict;
    verdict_t want_verdict;

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got_verdict.deliver = out_ch.deliver;
            got_verdict.forward = out_ch.forward;
            got_verdict.forward_hops = out_ch.forward_hops;
            got_verdict.tx_seqno = out_ch.tx_seqno;
            got_verdict.send_done = out_ch.send_done;
            if (pending_verdicts.size() == 0)
            begin
                flag_error($sformatf({"unexpected verdict: deliver=%0b forward=%0b",
                    " hops=%0d tx_seqno=%0d send_done=%0b"},
                    got_verdict.deliver, got_verdict.forward, got_verdict.forward_hops,
                    got_verdict.tx_seqno, got_verdict.send_done));
            end
            else
            begin
                want_verdict = pending_verdicts.pop_front();
                if (got_verdict.deliver !== want_verdict.deliver
                    || got_verdict.forward !== want_verdict.forward
                    || got_verdict.forward_hops !== want_verdict.forward_hops
                    || got_verdict.tx_seqno !== want_verdict.tx_seqno
                    || got_verdict.send_done !== want_verdict.send_done)
                begin
                    flag_error($sformatf({"verdict mismatch: expected deliver=%0b forward=%0b",
                        " hops=%0d tx_seqno=%0d send_done=%0b, got deliver=%0b forward=%0b",
                        " hops=%0d tx_seqno=%0d send_done=%0b"},
                        want_verdict.deliver, want_verdict.forward, want_verdict.forward_hops,
                        want_verdict.tx_seqno, want_verdict.send_done,
                        got_verdict.deliver, got_verdict.forward, got_verdict.forward_hops,
                        got_verdict.tx_seqno, got_verdict.send_done));
                end
            end
        end
    end

    task automatic write_register(input cfg_index_t idx, input cfg_data_t data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_HOP_LIMIT)
        begin
            cfg_hop_limit = data[7:0];
        end
        else
        begin
            cfg_node_address = data;
        end
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Wait until every packet is sent and every verdict has come back.
    task automatic settle();
        while (packet_backlog.size() > 0 || in_ch.valid || pending_verdicts.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (VERDICT_LATENCY + 4) @(posedge clk);
    endtask

    // Originators mostly send in order; some retransmit, some send noise.
    task automatic queue_random_items(input int pool_size, input int count);
        addr_t pool_addr [MAX_POOL];
        seq_t pool_seq [MAX_POOL];
        int k;
        int pick;
        int lim;
        addr_t addr;
        hop_t hops;
        logic [6:0] cnt;
        for (int i = 0; i < MAX_POOL; i++)
        begin
            pool_addr[i] = addr_t'($urandom);
            pool_seq[i] = seq_t'($urandom);
        end
        pool_addr[0] = cfg_node_address;
        lim = cfg_hop_limit;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                packet_backlog.push_back(send_pkt($urandom_range(0, 4) != 0));
            end
            else
            begin
                k = $urandom_range(0, pool_size - 1);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    cnt = pool_seq[k][7:1] + 7'd1;
                    pool_seq[k] = {cnt, pool_seq[k][0] ^ (cnt == 7'd0)};
                end
                else if (pick == 9)
                begin
                    pool_seq[k] = seq_t'($urandom);
                end
                addr = ($urandom_range(0, 19) == 0) ? addr_t'($urandom) : pool_addr[k];
                if ($urandom_range(0, 3) != 0)
                begin
                    hops = hop_t'($urandom_range(0, (lim >= 255) ? 255 : lim + 1));
                end
                else
                begin
                    hops = hop_t'($urandom);
                end
                packet_backlog.push_back(recv_pkt(addr, pool_seq[k], hops,
                    $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0));
            end
        end
    endtask

    task automatic run_phase(input hop_t hop_lim, input addr_t node, input int pool_size,
                             input int count, input idle_mode_t smode,
                             input idle_mode_t rmode, input bit long_hold);
        write_register(REG_HOP_LIMIT, {8'($urandom), hop_lim});
        write_register(REG_NODE_ADDRESS, node);
        sender_mode <= smode;
        receiver_mode <= rmode;
        if (long_hold)
        begin
            hold_requests <= hold_requests + 1;
        end
        queue_random_items(pool_size, count);
        settle();
    endtask

    // Main sequence: reset, directed packets, then random phases.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_HOP_LIMIT;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OPCODE_RECV;
        in_ch.originator_addr = '0;
        in_ch.rx_seqno = '0;
        in_ch.hop_count = '0;
        in_ch.app_accepts = 1'b0;
        in_ch.buffer_available = 1'b0;
        in_ch.send_ok = 1'b0;
        out_ch.ready = 1'b0;
        error_count = 0;
        sender_mode = IDLE_LIGHT;
        receiver_mode = IDLE_LIGHT;
        hold_requests = 0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            origin_addr_tbl[i] = '0;
            origin_seq_tbl[i] = '0;
            origin_valid_tbl[i] = 1'b0;
        end
        ring_slot = 0;
        own_counter = '0;
        cfg_hop_limit = HOP_LIMIT_RESET;
        cfg_node_address = NODE_ADDRESS_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed packets under the reset configuration.
        // New originator, retransmission, larger count at the hop boundary.
        packet_backlog.push_back(recv_pkt(16'h0000, 8'h00, 8'd0, 1'b1, 1'b1));
        packet_backlog.push_back(recv_pkt(16'h0000, 8'h00, 8'd0, 1'b1, 1'b1));
        packet_backlog.push_back(recv_pkt(16'h0000, 8'h02, 8'd15, 1'b1, 1'b1));
        // Smaller count with a flipped wrap marker is new; equal count is not.
        packet_backlog.push_back(recv_pkt(16'h0000, 8'h01, 8'd3, 1'b1, 1'b1));
        packet_backlog.push_back(recv_pkt(16'h0000, 8'h00, 8'd3, 1'b1, 1'b1));
        // Delivered but not forwarded: hop limit reached, no app, no buffer.
        packet_backlog.push_back(recv_pkt(16'hFFFF, 8'hFF, 8'd16, 1'b1, 1'b1));
        packet_backlog.push_back(recv_pkt(16'hFFFF, 8'hFE, 8'd255, 1'b1, 1'b1));
        packet_backlog.push_back(recv_pkt(16'hFFFF, 8'hFE, 8'd0, 1'b0, 1'b1));
        packet_backlog.push_back(recv_pkt(16'hFFFF, 8'hFE, 8'd0, 1'b1, 1'b0));
        packet_backlog.push_back(recv_pkt(16'hFFFF, 8'hFE, 8'd0, 1'b1, 1'b1));
        // Count at its top, then the wrap back to zero.
        packet_backlog.push_back(recv_pkt(16'hFFFF, 8'hFF, 8'd0, 1'b1, 1'b1));
        packet_backlog.push_back(recv_pkt(16'hFFFF, 8'h01, 8'd0, 1'b1, 1'b1));
        packet_backlog.push_back(recv_pkt(16'hFFFF, 8'h00, 8'd0, 1'b1, 1'b1));
        // Local sends: a failed one still reports the header number.
        packet_backlog.push_back(send_pkt(1'b0));
        packet_backlog.push_back(send_pkt(1'b1));
        packet_backlog.push_back(send_pkt(1'b1));
        // Received packet for our own address after local sends.
        packet_backlog.push_back(recv_pkt(16'h0000, 8'h04, 8'd1, 1'b1, 1'b1));
        packet_backlog.push_back(recv_pkt(16'h0000, 8'h02, 8'd1, 1'b1, 1'b1));
        packet_backlog.push_back(recv_pkt(16'h5AA5, 8'h80, 8'd7, 1'b1, 1'b1));
        packet_backlog.push_back(send_pkt(1'b1));
        settle();

        run_phase(8'd255, 16'hFFFF, 8, 250, IDLE_HEAVY, IDLE_HEAVY, 1'b0);
        run_phase(8'd0, addr_t'($urandom), 24, 200, IDLE_NONE, IDLE_NONE, 1'b0);
        run_phase(8'd16, 16'h0000, 12, 250, IDLE_NONE, IDLE_LIGHT, 1'b1);
        run_phase(8'd1, addr_t'($urandom), 24, 200, IDLE_LIGHT, IDLE_HEAVY, 1'b0);
        run_phase(hop_t'($urandom), addr_t'($urandom), 6, 250, IDLE_LIGHT, IDLE_LIGHT, 1'b0);
        run_phase(8'd200, 16'h8001, 20, 230, IDLE_HEAVY, IDLE_NONE, 1'b0);

        if (error_count == 0)
        begin
            $display("flood_duplicate_filter_core_tb: done, clean");
        end
        else
        begin
            $display("flood_duplicate_filter_core_tb: done, errors");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(5_000_000);
        $display("flood_duplicate_filter_core_tb: done, errors");
        $finish;
    end

endmodule
